// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/core/tplc_pkg.sv
`timescale 1ns / 1ps

package tplc_pkg;

    // Quotient bits kept by the divider; anything larger saturates.
    localparam int QUO_BITS = 33;

    localparam logic [2:0] LOC_INSIDE  = 3'd0;
    localparam logic [2:0] LOC_VERTEX  = 3'd1;
    localparam logic [2:0] LOC_EDGE    = 3'd2;
    localparam logic [2:0] LOC_OUTSIDE = 3'd3;
    localparam logic [2:0] LOC_DEGEN   = 3'd4;

    // Numerator signs that ride along with a transaction through the divider.
    typedef struct packed {
        logic neg_a;
        logic neg_b;
    } t_tag;

endpackage

// File: rtl/core/tplc_div.sv
`timescale 1ns / 1ps

module tplc_div #(
    parameter int DEN_W     = 51,
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  tplc_pkg::t_tag                   i_tag,
    input  logic [DEN_W+FRAC_BITS-1:0]       i_num_a,
    input  logic [DEN_W+FRAC_BITS-1:0]       i_num_b,
    input  logic [DEN_W-1:0]                 i_den,
    output logic                             o_valid,
    output tplc_pkg::t_tag                   o_tag,
    output logic                             o_ovf_a,
    output logic                             o_ovf_b,
    output logic [tplc_pkg::QUO_BITS-1:0]    o_quo_a,
    output logic [tplc_pkg::QUO_BITS-1:0]    o_quo_b
);

    localparam int QB    = tplc_pkg::QUO_BITS;
    localparam int NW    = DEN_W + FRAC_BITS;
    localparam int CMP_W = NW + QB;

    logic [NW-1:0]    w_num [0:1];
    logic             r_v   [0:QB];
    tplc_pkg::t_tag   r_tag [0:QB];
    logic [DEN_W-1:0] r_rem [0:1][0:QB];
    logic [QB-1:0]    r_lo  [0:1][0:QB];
    logic [QB-1:0]    r_q   [0:1][0:QB];
    logic             r_ovf [0:1][0:QB];

    assign w_num[0] = i_num_a;
    assign w_num[1] = i_num_b;

    // Control: valid and tag shift with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [CMP_W-1:0] w_den_sh;
        logic [CMP_W-1:0] w_num_e;

        // Range check: quotient fits QB bits only if num < den << QB.
        assign w_den_sh = CMP_W'(i_den) << QB;
        assign w_num_e  = CMP_W'(w_num[l]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[l][0] <= DEN_W'(w_num[l] >> QB);
                r_lo[l][0]  <= QB'(w_num[l]);
                r_q[l][0]   <= '0;
                r_ovf[l][0] <= (w_num_e >= w_den_sh);
            end
        end

        // One restoring step per stage, MSB of the quotient first.
        for (genvar k = 1; k <= QB; k++) begin : g_step
            logic [DEN_W:0]   w_trial;
            logic [DEN_W:0]   w_diff;
            logic             w_ge;
            logic [DEN_W-1:0] n_rem;
            logic [QB-1:0]    n_q;

            always_comb begin
                w_trial = {r_rem[l][k-1], r_lo[l][k-1][QB-k]};
                w_diff  = w_trial - (DEN_W+1)'(i_den);
                w_ge    = (w_trial >= (DEN_W+1)'(i_den));
                n_rem   = w_ge ? DEN_W'(w_diff) : DEN_W'(w_trial);
                n_q     = r_q[l][k-1];
                n_q[QB-k] = w_ge;
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][k] <= n_rem;
                    r_lo[l][k]  <= r_lo[l][k-1];
                    r_q[l][k]   <= n_q;
                    r_ovf[l][k] <= r_ovf[l][k-1];
                end
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_tag   = r_tag[QB];
    assign o_ovf_a = r_ovf[0][QB];
    assign o_ovf_b = r_ovf[1][QB];
    assign o_quo_a = r_q[0][QB];
    assign o_quo_b = r_q[1][QB];

endmodule

// File: rtl/core/triangle_point_location_classifier.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+------------------------------------
// point in  | input     | i_in_valid / o_in_ready   | i_point_x, i_point_y
// result    | output    | o_out_valid / i_out_ready | o_location, o_lambda_first/second/third
// config    | input     | i_cfg_wr_en (no wait)     | i_cfg_index, i_cfg_data
//
// One query point enters per cycle while the output is not held; the bit-per-stage
// restoring divider forms both weights side by side.
// Reset is synchronous, active low, and empties the pipeline; config takes reset values.
// When the result is held by the consumer the whole pipeline freezes in place, bubbles
// included; nothing advances until the output register is read, so no transaction is
// lost or repeated.
// Derived terms settle after a config write via edge, product, cross, magnitude registers.

module triangle_point_location_classifier #(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_in_valid,
    output logic                                              o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]                     i_point_x,
    input  logic signed [COORD_WIDTH-1:0]                     i_point_y,
    output logic                                              o_out_valid,
    input  logic                                              i_out_ready,
    output logic [2:0]                                        o_location,
    output logic signed [31:0]                                o_lambda_first,
    output logic signed [31:0]                                o_lambda_second,
    output logic signed [31:0]                                o_lambda_third,
    input  logic                                              i_cfg_wr_en,
    input  logic [2:0]                                        i_cfg_index,
    input  logic [(COORD_WIDTH > 16 ? COORD_WIDTH : 16)-1:0]  i_cfg_data
);

    localparam int W   = COORD_WIDTH;
    localparam int EW  = W + 1;           // edge / offset vectors
    localparam int PW  = 2 * EW;          // single product
    localparam int XW  = PW + 1;          // cross product
    localparam int NW  = XW + FRAC_BITS;  // scaled numerator magnitude
    localparam int QB  = tplc_pkg::QUO_BITS;
    localparam int SW  = 34;              // headroom for weight arithmetic
    localparam int TSL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int TSR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [SW-1:0] ONE_S = SW'(1 << FRAC_BITS);

    localparam logic [2:0] CFG_V0X = 3'd0;
    localparam logic [2:0] CFG_V0Y = 3'd1;
    localparam logic [2:0] CFG_V1X = 3'd2;
    localparam logic [2:0] CFG_V1Y = 3'd3;
    localparam logic [2:0] CFG_V2X = 3'd4;
    localparam logic [2:0] CFG_V2Y = 3'd5;
    localparam logic [2:0] CFG_TOL = 3'd6;

    // ---------------- configuration ----------------
    logic signed [W-1:0] r_v0x, r_v0y, r_v1x, r_v1y, r_v2x, r_v2y;
    logic [15:0]         r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0x <= '0;
            r_v0y <= '0;
            r_v1x <= W'(4096);
            r_v1y <= '0;
            r_v2x <= '0;
            r_v2y <= W'(4096);
            r_tol <= 16'd66;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_V0X: r_v0x <= i_cfg_data[W-1:0];
                CFG_V0Y: r_v0y <= i_cfg_data[W-1:0];
                CFG_V1X: r_v1x <= i_cfg_data[W-1:0];
                CFG_V1Y: r_v1y <= i_cfg_data[W-1:0];
                CFG_V2X: r_v2x <= i_cfg_data[W-1:0];
                CFG_V2Y: r_v2y <= i_cfg_data[W-1:0];
                CFG_TOL: r_tol <= i_cfg_data[15:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Triangle terms: edges, edge products, cross product; no per-item copy. The user must
    // keep them stable while transactions are in flight; the block does not enforce it.
    logic signed [EW-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [PW-1:0] r_dp1, r_dp2;
    logic signed [XW-1:0] r_den;
    logic [XW-1:0]        r_den_mag;
    logic                 r_den_neg;
    logic                 r_den_zero;

    always_ff @(posedge i_clk) begin
        r_e1x      <= EW'(r_v1x) - EW'(r_v0x);
        r_e1y      <= EW'(r_v1y) - EW'(r_v0y);
        r_e2x      <= EW'(r_v2x) - EW'(r_v0x);
        r_e2y      <= EW'(r_v2y) - EW'(r_v0y);
        r_dp1      <= r_e1x * r_e2y;
        r_dp2      <= r_e1y * r_e2x;
        r_den      <= XW'(r_dp1) - XW'(r_dp2);
        r_den_neg  <= r_den[XW-1];
        r_den_zero <= (r_den == '0);
        r_den_mag  <= r_den[XW-1] ? XW'(-r_den) : XW'(r_den);
    end

    logic signed [SW-1:0] w_tol;
    assign w_tol = (SW'(r_tol) << TSL) >> TSR;

    // ---------------- datapath pipeline ----------------
    // One enable for every stage: advance unless a result is stuck at the output.
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // S1: offset of the point from the first vertex.
    logic                 r_s1_v;
    logic signed [EW-1:0] r_s1_wx, r_s1_wy;
    // S2: the four products of the two numerator cross products.
    logic                 r_s2_v;
    logic signed [PW-1:0] r_s2_pa, r_s2_pb, r_s2_pc, r_s2_pd;
    // S3: signed numerators.
    logic                 r_s3_v;
    logic signed [XW-1:0] r_s3_n1, r_s3_n2;
    // S4: magnitudes scaled by the fraction bits, signs kept apart.
    logic                 r_s4_v;
    logic [NW-1:0]        r_s4_num1, r_s4_num2;
    tplc_pkg::t_tag       r_s4_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_wx        <= EW'(i_point_x) - EW'(r_v0x);
            r_s1_wy        <= EW'(i_point_y) - EW'(r_v0y);
            r_s2_pa        <= r_s1_wx * r_e2y;
            r_s2_pb        <= r_s1_wy * r_e2x;
            r_s2_pc        <= r_e1x * r_s1_wy;
            r_s2_pd        <= r_e1y * r_s1_wx;
            r_s3_n1        <= XW'(r_s2_pa) - XW'(r_s2_pb);
            r_s3_n2        <= XW'(r_s2_pc) - XW'(r_s2_pd);
            r_s4_tag.neg_a <= r_s3_n1[XW-1];
            r_s4_tag.neg_b <= r_s3_n2[XW-1];
            r_s4_num1      <= {(r_s3_n1[XW-1] ? XW'(-r_s3_n1) : XW'(r_s3_n1)),
                               {FRAC_BITS{1'b0}}};
            r_s4_num2      <= {(r_s3_n2[XW-1] ? XW'(-r_s3_n2) : XW'(r_s3_n2)),
                               {FRAC_BITS{1'b0}}};
        end
    end

    // Divider: both weights share the denominator magnitude.
    logic           w_dv_v;
    tplc_pkg::t_tag w_dv_tag;
    logic           w_ovf1, w_ovf2;
    logic [QB-1:0]  w_q1, w_q2;

    tplc_div #(
        .DEN_W     (XW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s4_v),
        .i_tag   (r_s4_tag),
        .i_num_a (r_s4_num1),
        .i_num_b (r_s4_num2),
        .i_den   (r_den_mag),
        .o_valid (w_dv_v),
        .o_tag   (w_dv_tag),
        .o_ovf_a (w_ovf1),
        .o_ovf_b (w_ovf2),
        .o_quo_a (w_q1),
        .o_quo_b (w_q2)
    );

    // Apply the sign, then clamp to the 32-bit range.
    function automatic logic signed [31:0] sat_quo(input logic neg, input logic ovf,
                                                   input logic [QB-1:0] q);
        logic signed [31:0] res;
        if (!neg) begin
            res = (ovf || q > QB'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : q[31:0];
        end else begin
            res = (ovf || q > QB'(32'h8000_0000)) ? 32'sh8000_0000 : -q[31:0];
        end
        return res;
    endfunction

    // Clamp a widened sum back to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] x);
        logic signed [31:0] res;
        if (x > SW'(32'sh7FFF_FFFF)) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < SW'(32'sh8000_0000)) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // S5: saturated second and third weights.
    logic               r_s5_v;
    logic signed [31:0] r_s5_l1, r_s5_l2;
    // S6: first weight from the other two.
    logic               r_s6_v;
    logic signed [31:0] r_s6_l0, r_s6_l1, r_s6_l2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else if (w_en) begin
            r_s5_v <= w_dv_v;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_l1 <= sat_quo(w_dv_tag.neg_a ^ r_den_neg, w_ovf1, w_q1);
            r_s5_l2 <= sat_quo(w_dv_tag.neg_b ^ r_den_neg, w_ovf2, w_q2);
            r_s6_l0 <= sat32(ONE_S - SW'(r_s5_l1) - SW'(r_s5_l2));
            r_s6_l1 <= r_s5_l1;
            r_s6_l2 <= r_s5_l2;
        end
    end

    // S7: classify against the tolerance band and load the output register.
    logic                 w_bt0, w_bt1, w_bt2, w_z0, w_z1, w_z2, w_o0, w_o1, w_o2;
    logic signed [SW-1:0] w_x0, w_x1, w_x2;
    logic [2:0]           w_loc;

    always_comb begin
        w_x0  = SW'(r_s6_l0);
        w_x1  = SW'(r_s6_l1);
        w_x2  = SW'(r_s6_l2);
        w_bt0 = (w_x0 > w_tol) && (w_x0 - ONE_S < -w_tol);
        w_bt1 = (w_x1 > w_tol) && (w_x1 - ONE_S < -w_tol);
        w_bt2 = (w_x2 > w_tol) && (w_x2 - ONE_S < -w_tol);
        w_z0  = (w_x0 > -w_tol) && (w_x0 < w_tol);
        w_z1  = (w_x1 > -w_tol) && (w_x1 < w_tol);
        w_z2  = (w_x2 > -w_tol) && (w_x2 < w_tol);
        w_o0  = (w_x0 - ONE_S > -w_tol) && (w_x0 - ONE_S < w_tol);
        w_o1  = (w_x1 - ONE_S > -w_tol) && (w_x1 - ONE_S < w_tol);
        w_o2  = (w_x2 - ONE_S > -w_tol) && (w_x2 - ONE_S < w_tol);
        if (r_den_zero) begin
            w_loc = tplc_pkg::LOC_DEGEN;
        end else if (w_bt0 && w_bt1 && w_bt2) begin
            w_loc = tplc_pkg::LOC_INSIDE;
        end else if ((w_z0 && w_z1 && w_o2) || (w_z0 && w_z2 && w_o1) ||
                     (w_z2 && w_z1 && w_o0)) begin
            w_loc = tplc_pkg::LOC_VERTEX;
        end else if ((w_bt0 && w_bt1 && w_z2) || (w_bt0 && w_bt2 && w_z1) ||
                     (w_bt2 && w_bt1 && w_z0)) begin
            w_loc = tplc_pkg::LOC_EDGE;
        end else begin
            w_loc = tplc_pkg::LOC_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_en) begin
            o_out_valid <= r_s6_v;
        end
    end

    // Degenerate triangle: report zero weights.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_location      <= w_loc;
            o_lambda_first  <= r_den_zero ? '0 : r_s6_l0;
            o_lambda_second <= r_den_zero ? '0 : r_s6_l1;
            o_lambda_third  <= r_den_zero ? '0 : r_s6_l2;
        end
    end

endmodule

// File: rtl/core/tplc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tplc_sva (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         o_location,
    input logic signed [31:0] o_lambda_first,
    input logic signed [31:0] o_lambda_second,
    input logic signed [31:0] o_lambda_third
);

    // Held result keeps its payload.
    `CHK_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_location) && $stable(o_lambda_first) && $stable(o_lambda_second) && $stable(o_lambda_third))

    // An empty output register never blocks the input.
    `CHK_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // Degenerate triangles carry zero weights.
    `CHK_IMPLY(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_location == tplc_pkg::LOC_DEGEN, o_lambda_first == 32'sd0 && o_lambda_second == 32'sd0 && o_lambda_third == 32'sd0)

    // Strictly inside means every weight is positive.
    `CHK_IMPLY(a_inside_pos, i_clk, i_rst_n, o_out_valid && o_location == tplc_pkg::LOC_INSIDE, o_lambda_first > 32'sd0 && o_lambda_second > 32'sd0 && o_lambda_third > 32'sd0)

endmodule

bind triangle_point_location_classifier tplc_sva u_tplc_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_location      (o_location),
    .o_lambda_first  (o_lambda_first),
    .o_lambda_second (o_lambda_second),
    .o_lambda_third  (o_lambda_third)
);
